/* rtl/tgv_pkg.sv */
package tgv_pkg;
    localparam int ACCEL_WIDTH = 19;
    localparam int AW = ACCEL_WIDTH;
    localparam int SQW = 2 * AW + 2;
    localparam int RTW = AW + 1;
    localparam int DW = 2 * AW + 16;

    localparam logic CFG_MIN_MAGNITUDE = 1'b0;
    localparam logic CFG_FALLBACK_GRAVITY = 1'b1;
    localparam logic [15:0] MIN_MAG_RESET = 16'd500;
    localparam logic [17:0] FALLBACK_RESET = 18'd9812;
    localparam logic [14:0] Q14_ONE = 15'd16384;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_SQA  = 7'b0000010,
        ST_SQB  = 7'b0000100,
        ST_ROOT = 7'b0001000,
        ST_MSET = 7'b0010000,
        ST_DIV  = 7'b0100000,
        ST_OUT  = 7'b1000000
    } state_t;
endpackage

/* rtl/tgv_sqrt.sv */
module tgv_sqrt (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [tgv_pkg::SQW-1:0]     radicand,
    output logic                        done,
    output logic [tgv_pkg::RTW-1:0]     root
);
    import tgv_pkg::*;

    localparam int STEPS = SQW / 2;
    localparam int CW = $clog2(STEPS + 1);

    logic [SQW-1:0] rad_reg;
    logic [RTW+1:0] rem_reg;
    logic [RTW-1:0] root_reg;
    logic [CW-1:0]  cnt_reg;
    logic           busy_reg;
    logic           done_reg;
    logic [RTW+1:0] rem_shift;
    logic [RTW+1:0] trial;

    // one result bit per cycle, two radicand bits shifted in
    assign rem_shift = {rem_reg[RTW-1:0], rad_reg[SQW-1 -: 2]};
    assign trial = {root_reg, 2'b01};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            // flag the cycle after the last step, once the root has settled
            done_reg <= busy_reg && (cnt_reg == CW'(1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(STEPS);
                rad_reg  <= radicand;
                rem_reg  <= '0;
                root_reg <= '0;
            end else if (busy_reg) begin
                rad_reg <= {rad_reg[SQW-3:0], 2'b00};
                if (rem_shift >= trial) begin
                    rem_reg  <= rem_shift - trial;
                    root_reg <= {root_reg[RTW-2:0], 1'b1};
                end else begin
                    rem_reg  <= rem_shift;
                    root_reg <= {root_reg[RTW-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) busy_reg <= 1'b0;
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule

/* rtl/tgv_div.sv */
module tgv_div (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [tgv_pkg::DW-1:0]   dividend,
    input  logic [tgv_pkg::DW-1:0]   divisor,
    output logic                     done,
    output logic [tgv_pkg::DW-1:0]   quotient
);
    import tgv_pkg::*;

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] quo_reg;
    logic [DW:0]   rem_reg;
    logic [DW-1:0] dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [DW:0]   rem_shift;

    // restoring division, one quotient bit per cycle
    assign rem_shift = {rem_reg[DW-1:0], quo_reg[DW-1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            // flag the cycle after the last step, once the quotient has settled
            done_reg <= busy_reg && (cnt_reg == CW'(1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DW);
                quo_reg  <= dividend;
                rem_reg  <= '0;
                dvs_reg  <= divisor;
            end else if (busy_reg) begin
                if (rem_shift >= {1'b0, dvs_reg}) begin
                    rem_reg <= rem_shift - {1'b0, dvs_reg};
                    quo_reg <= {quo_reg[DW-2:0], 1'b1};
                end else begin
                    rem_reg <= rem_shift;
                    quo_reg <= {quo_reg[DW-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) busy_reg <= 1'b0;
            end
        end
    end

    assign done = done_reg;
    assign quotient = quo_reg;
endmodule

/* rtl/tilt_from_gravity_vector.sv */
// Tilt from a gravity vector. One sample at a time: squares are formed with
// one shared multiplier, then two square roots (horizontal and full length)
// run one bit per cycle on a shared root unit (ACCEL_WIDTH+1 steps each),
// then two divisions (tilt sine and direction ratio) run one quotient bit per
// cycle on a shared divider (2*ACCEL_WIDTH+16 steps each); each unit hands
// over its result in the cycle after its last step. The next sample is taken
// only once the result has been loaded into the output register, and not
// while the previous result still waits there unaccepted. Configuration
// writes are accepted at any time and should be made while idle.
module tilt_from_gravity_vector (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [tgv_pkg::AW-1:0]       s_accel_x,
    input  logic signed [tgv_pkg::AW-1:0]       s_accel_y,
    input  logic signed [tgv_pkg::AW-1:0]       s_accel_z,
    input  logic                                s_sample_valid,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [18:0]                         m_magnitude,
    output logic [14:0]                         m_tilt_sine_q14,
    output logic [6:0]                          m_tilt_degrees,
    output logic [11:0]                         m_direction_decideg,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic                                cfg_index,
    input  logic [17:0]                         cfg_data
);
    import tgv_pkg::*;

    state_t state_reg;
    logic [1:0] sub_reg;
    logic [15:0] minmag_reg;
    logic [17:0] fallback_reg;
    logic [AW-1:0] ax_reg, ay_reg, az_reg;
    logic xneg_reg, yneg_reg;
    logic [2*AW-1:0] sqx_reg, sqy_reg, sqz_reg;
    logic [RTW-1:0] horiz_reg, mag_reg;
    logic [DW-1:0] tilt_q_reg;
    logic mvalid_reg;
    logic [18:0] omag_reg;
    logic [14:0] otilt_reg;
    logic [6:0] odeg_reg;
    logic [11:0] odir_reg;

    logic [AW-1:0] absx, absy, absz;
    logic [AW-1:0] mul_a, mul_b;
    logic [2*AW-1:0] mul_p;
    logic sq_start, sq_done, dv_start, dv_done;
    logic [SQW-1:0] sq_rad;
    logic [RTW-1:0] sq_root;
    logic [DW-1:0] dv_n, dv_d, dv_q;
    logic [RTW-1:0] mag_fix;
    logic b_ge_a;
    logic [2*AW-1:0] big_sq, sml_sq, ab;
    logic [14:0] tilt_sat;
    logic [21:0] deg_prod;
    logic [11:0] ang, ang1, ang2;
    logic [12:0] ang3;

    assign cfg_ready = 1'b1;
    assign s_ready = (state_reg == ST_IDLE);

    // hold configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            minmag_reg   <= MIN_MAG_RESET;
            fallback_reg <= FALLBACK_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_MIN_MAGNITUDE:    minmag_reg <= cfg_data[15:0];
                CFG_FALLBACK_GRAVITY: fallback_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign absx = s_accel_x[AW-1] ? AW'(-s_accel_x) : s_accel_x;
    assign absy = s_accel_y[AW-1] ? AW'(-s_accel_y) : s_accel_y;
    assign absz = s_accel_z[AW-1] ? AW'(-s_accel_z) : s_accel_z;

    // shared multiplier, one product per cycle
    always_comb begin
        case (sub_reg)
            2'd0:    begin mul_a = ax_reg; mul_b = ax_reg; end
            2'd1:    begin mul_a = ay_reg; mul_b = ay_reg; end
            2'd2:    begin mul_a = az_reg; mul_b = az_reg; end
            default: begin mul_a = ax_reg; mul_b = ay_reg; end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    assign b_ge_a = (ay_reg >= ax_reg);
    assign big_sq = b_ge_a ? sqy_reg : sqx_reg;
    assign sml_sq = b_ge_a ? sqx_reg : sqy_reg;
    assign ab = sqz_reg;

    assign mag_fix = (mag_reg < RTW'(minmag_reg)) ? RTW'(fallback_reg) : mag_reg;

    always_comb begin
        sq_start = 1'b0;
        sq_rad = '0;
        dv_start = 1'b0;
        dv_n = '0;
        dv_d = '0;
        if (state_reg == ST_SQB) begin
            sq_start = (sub_reg == 2'd3);
            sq_rad = SQW'(sqx_reg) + SQW'(sqy_reg);
        end else if (state_reg == ST_ROOT && sq_done && sub_reg == 2'd0) begin
            sq_start = 1'b1;
            sq_rad = SQW'(sqx_reg) + SQW'(sqy_reg) + SQW'(sqz_reg);
        end
        if (state_reg == ST_MSET) begin
            dv_start = 1'b1;
            dv_n = DW'(horiz_reg) << 14;
            dv_d = DW'(mag_fix);
        end else if (state_reg == ST_DIV && dv_done && sub_reg == 2'd0) begin
            dv_start = 1'b1;
            dv_n = DW'(ab) * DW'(14'd10314);
            dv_d = DW'(big_sq) * DW'(5'd18) + DW'(sml_sq) * DW'(3'd5) + DW'(1);
        end
    end

    tgv_sqrt u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .start(sq_start), .radicand(sq_rad),
        .done(sq_done), .root(sq_root)
    );

    tgv_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(dv_start), .dividend(dv_n),
        .divisor(dv_d), .done(dv_done), .quotient(dv_q)
    );

    // saturate the tilt sine, scale it to degrees, and fold the ratio into the full circle
    assign tilt_sat = (mag_reg == '0) ? ((horiz_reg != '0) ? Q14_ONE : 15'd0) :
                      ((tilt_q_reg > DW'(Q14_ONE)) ? Q14_ONE : tilt_q_reg[14:0]);
    assign deg_prod = 22'(tilt_sat) * 22'd90;
    assign ang = b_ge_a ? dv_q[11:0] : 12'd900 - dv_q[11:0];
    assign ang1 = yneg_reg ? 12'd1800 - ang : ang;
    assign ang2 = xneg_reg ? 12'd3600 - ang1 : ang1;
    assign ang3 = (ax_reg == '0 && ay_reg == '0) ? 13'd0 :
                  ((ang2 >= 12'd3600) ? 13'(ang2 - 12'd3600) : 13'(ang2));

    // sequence one sample
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            sub_reg    <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            if (mvalid_reg && m_ready && state_reg != ST_OUT) mvalid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        ax_reg   <= s_sample_valid ? absx : '0;
                        ay_reg   <= s_sample_valid ? absy : '0;
                        az_reg   <= s_sample_valid ? absz : AW'(fallback_reg);
                        xneg_reg <= s_sample_valid & s_accel_x[AW-1];
                        yneg_reg <= s_sample_valid & s_accel_y[AW-1];
                        sub_reg  <= 2'd0;
                        state_reg <= ST_SQA;
                    end
                end
                ST_SQA: begin
                    case (sub_reg)
                        2'd0:    sqx_reg <= mul_p;
                        2'd1:    sqy_reg <= mul_p;
                        default: sqz_reg <= mul_p;
                    endcase
                    sub_reg <= sub_reg + 1'b1;
                    if (sub_reg == 2'd2) state_reg <= ST_SQB;
                end
                ST_SQB: begin
                    sub_reg <= 2'd0;
                    state_reg <= ST_ROOT;
                end
                ST_ROOT: begin
                    if (sq_done) begin
                        if (sub_reg == 2'd0) begin
                            horiz_reg <= sq_root;
                            sub_reg <= 2'd3;
                        end else begin
                            mag_reg <= sq_root;
                            state_reg <= ST_MSET;
                        end
                    end else if (sub_reg == 2'd3) begin
                        // z square is consumed, reuse its register for a*b
                        sqz_reg <= mul_p;
                    end
                end
                ST_MSET: begin
                    mag_reg <= mag_fix;
                    sub_reg <= 2'd0;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (dv_done) begin
                        if (sub_reg == 2'd0) begin
                            tilt_q_reg <= dv_q;
                            sub_reg <= 2'd1;
                        end else begin
                            state_reg <= ST_OUT;
                        end
                    end
                end
                ST_OUT: begin
                    if (!mvalid_reg || m_ready) begin
                        mvalid_reg <= 1'b1;
                        omag_reg   <= 19'(mag_reg);
                        otilt_reg  <= tilt_sat;
                        odeg_reg   <= deg_prod[20:14];
                        odir_reg   <= ang3[11:0];
                        state_reg  <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid = mvalid_reg;
    assign m_magnitude = omag_reg;
    assign m_tilt_sine_q14 = otilt_reg;
    assign m_tilt_degrees = odeg_reg;
    assign m_direction_decideg = odir_reg;
endmodule
